// ===== rtl/clne_pkg.sv =====
// Shared types, constants and nibble tables for the character LCD expander encoder.
// Used by clne_front, clne_queue, clne_back and the top level; no dependencies.
package clne_pkg;

  // Screen geometry of the 20x4 display.
  localparam int LINE_LENGTH  = 20;
  localparam int SCREEN_CHARS = 80;
  localparam int CURSOR_W     = 7;

  // Nibble-write index within one queued entry (up to fourteen writes).
  localparam int NIB_IDX_W = 4;

  // Item kinds on the input channel.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_INIT = 1'b1;

  // Board wiring codes.
  localparam logic WIRING_LOW  = 1'b0;
  localparam logic WIRING_HIGH = 1'b1;

  // Display command bytes.
  localparam logic [7:0] CMD_LINE2     = 8'hC0;
  localparam logic [7:0] CMD_LINE3     = 8'h94;
  localparam logic [7:0] CMD_LINE4     = 8'hD4;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_ADDR_ZERO = 8'h80;
  localparam logic [3:0] WAKE_NIB      = 4'h3;
  localparam logic [3:0] WAKE_LAST_NIB = 4'h2;
  localparam logic [7:0] FIRST_PRINT   = 8'h20;
  localparam logic [7:0] RS_HIGH_WIRE  = 8'h08;
  localparam logic [7:0] RS_LOW_WIRE   = 8'h10;

  // Last nibble-write index for each kind of entry.
  localparam logic [NIB_IDX_W-1:0] INIT_LAST_HOME  = 4'd11;
  localparam logic [NIB_IDX_W-1:0] INIT_LAST_CLEAR = 4'd13;
  localparam logic [NIB_IDX_W-1:0] CHAR_LAST_LINE  = 4'd3;
  localparam logic [NIB_IDX_W-1:0] CHAR_LAST_PLAIN = 4'd1;

  // Line-address command that precedes a character.
  typedef enum logic [1:0] {
    LINE_NONE,
    LINE_TWO,
    LINE_THREE,
    LINE_FOUR
  } line_sel_t;

  // One word of work handed from the front to the back.
  typedef struct packed {
    logic       kind;
    logic       clr;
    line_sel_t  line_sel;
    logic [7:0] code;
  } entry_t;

  // A nibble write: register select and the four data bits.
  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
  } nib_write_t;

  // Index of the final nibble write of an entry.
  function automatic logic [NIB_IDX_W-1:0] last_index(input entry_t e);
    logic [NIB_IDX_W-1:0] r;
    if (e.kind == KIND_INIT) begin
      r = e.clr ? INIT_LAST_CLEAR : INIT_LAST_HOME;
    end else begin
      r = (e.line_sel != LINE_NONE) ? CHAR_LAST_LINE : CHAR_LAST_PLAIN;
    end
    return r;
  endfunction

  // Command byte for a line-address selection.
  function automatic logic [7:0] line_cmd(input line_sel_t s);
    logic [7:0] r;
    unique case (s)
      LINE_TWO:   r = CMD_LINE2;
      LINE_THREE: r = CMD_LINE3;
      LINE_FOUR:  r = CMD_LINE4;
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Nibble write number idx of an init sequence.
  function automatic logic [3:0] init_nib(input logic [NIB_IDX_W-1:0] idx, input logic clr);
    logic [7:0] mode;
    logic [3:0] r;
    mode = clr ? CMD_CLEAR : CMD_HOME;
    unique case (idx)
      4'd0, 4'd1, 4'd2: r = WAKE_NIB;
      4'd3:             r = WAKE_LAST_NIB;
      4'd4:             r = CMD_FUNC_SET[7:4];
      4'd5:             r = CMD_FUNC_SET[3:0];
      4'd6:             r = CMD_DISP_ON[7:4];
      4'd7:             r = CMD_DISP_ON[3:0];
      4'd8:             r = mode[7:4];
      4'd9:             r = mode[3:0];
      4'd10:            r = CMD_ENTRY[7:4];
      4'd11:            r = CMD_ENTRY[3:0];
      4'd12:            r = CMD_ADDR_ZERO[7:4];
      4'd13:            r = CMD_ADDR_ZERO[3:0];
      default:          r = '0;
    endcase
    return r;
  endfunction

  // Nibble write number idx of any entry.
  function automatic nib_write_t entry_nib(input entry_t e, input logic [NIB_IDX_W-1:0] idx);
    nib_write_t r;
    logic [1:0] pos;
    logic [7:0] cmd;
    r.rs  = 1'b0;
    r.nib = '0;
    // Without a line command the character starts at the third slot.
    pos = (e.line_sel != LINE_NONE) ? idx[1:0] : (idx[1:0] + 2'd2);
    cmd = line_cmd(e.line_sel);
    if (e.kind == KIND_INIT) begin
      r.nib = init_nib(idx, e.clr);
    end else begin
      case (pos)
        2'd0:    r.nib = cmd[7:4];
        2'd1:    r.nib = cmd[3:0];
        2'd2:    begin r.rs = 1'b1; r.nib = e.code[7:4]; end
        default: begin r.rs = 1'b1; r.nib = e.code[3:0]; end
      endcase
    end
    return r;
  endfunction

  // Place a nibble and register select on the expander pins.
  function automatic logic [7:0] place_nibble(input nib_write_t w, input logic wiring);
    logic [7:0] r;
    if (wiring == WIRING_HIGH) begin
      r = {w.nib, 4'h0} | (w.rs ? RS_HIGH_WIRE : 8'h00);
    end else begin
      r = {4'h0, w.nib} | (w.rs ? RS_LOW_WIRE : 8'h00);
    end
    return r;
  endfunction

endpackage

// ===== rtl/clne_front.sv =====
// Front end: accepts input words, tracks the cursor and classifies each word.
// Depends on clne_pkg; pushes one entry per word that produces output.
module clne_front import clne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] char_code,
  input  logic       clear_display,
  output logic       push,
  output entry_t     push_entry
);

  logic [CURSOR_W-1:0] cursor;
  logic [CURSOR_W-1:0] cursor_next;
  logic                on_screen;
  logic                printable;

  // Decide whether the word produces output and which line command goes first.
  always_comb begin
    on_screen             = cursor < CURSOR_W'(SCREEN_CHARS);
    printable             = char_code >= FIRST_PRINT;
    push                  = accept && ((kind == KIND_INIT) || (printable && on_screen));
    push_entry.kind       = kind;
    push_entry.clr        = clear_display;
    push_entry.code       = char_code;
    if (cursor == CURSOR_W'(LINE_LENGTH)) begin
      push_entry.line_sel = LINE_TWO;
    end else if (cursor == CURSOR_W'(2 * LINE_LENGTH)) begin
      push_entry.line_sel = LINE_THREE;
    end else if (cursor == CURSOR_W'(3 * LINE_LENGTH)) begin
      push_entry.line_sel = LINE_FOUR;
    end else begin
      push_entry.line_sel = LINE_NONE;
    end
  end

  // Init returns the cursor home; a written character advances it.
  always_comb begin
    cursor_next = cursor;
    if (accept && (kind == KIND_INIT)) begin
      cursor_next = '0;
    end else if (push) begin
      cursor_next = cursor + CURSOR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      cursor <= cursor_next;
    end
  end

endmodule

// ===== rtl/clne_queue.sv =====
// Two-entry queue of work entries between the front and the back end.
// Depends on clne_pkg for the entry type.
module clne_queue import clne_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/clne_back.sv =====
// Back end: expands queued entries into expander bytes, one per cycle while the output is not stalled.
// Depends on clne_pkg; drives the output register of the byte channel.
module clne_back import clne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wiring,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] port_byte,
  output logic       last_byte
);

  typedef enum logic [1:0] {
    PH_VALUE,
    PH_INVERT,
    PH_HOLD_A,
    PH_HOLD_B
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [NIB_IDX_W-1:0] idx;
  logic                 load;
  logic                 last_nib;
  logic [7:0]           value;
  logic [7:0]           byte_next;

  // Current byte from the head entry, nibble index and phase.
  always_comb begin
    value    = place_nibble(entry_nib(head, idx), wiring);
    last_nib = idx == last_index(head);
    load     = head_valid && (!out_valid || !out_stall);
    pop      = load && last_nib && (phase == PH_HOLD_B);
    unique case (phase)
      PH_VALUE:  begin byte_next = value;  phase_next = PH_INVERT; end
      PH_INVERT: begin byte_next = ~value; phase_next = PH_HOLD_A; end
      PH_HOLD_A: begin byte_next = 8'hFF;  phase_next = PH_HOLD_B; end
      default:   begin byte_next = 8'hFF;  phase_next = PH_VALUE;  end
    endcase
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_VALUE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
        if (phase == PH_HOLD_B) begin
          idx <= last_nib ? '0 : idx + NIB_IDX_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      port_byte <= byte_next;
      last_byte <= pop;
    end
  end

endmodule

// ===== rtl/char_lcd_nibble_expander_encoder_top.sv =====
// Top level of the character LCD nibble encoder for an 8-bit port expander.
// Depends on clne_pkg, clne_front, clne_queue and clne_back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   kind, char_code, clear_display
//   out      output     out_valid / out_stall port_byte, last_byte
//   config   input      wr_en                 wr_data (board wiring)
//
// Each nibble write becomes four bytes, one byte per cycle from the back end while the
// output is not stalled: a character word gives 8 or 16 bytes, an init word 48 or 56 bytes.
// Control codes and words past the end of the screen are taken but give no bytes.
// The front accepts a new word whenever the two-entry queue has room, so input
// and output stall independently.
// Reset is synchronous; it clears the cursor, the queue and sets wiring to 1.
module char_lcd_nibble_expander_encoder_top import clne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] char_code,
  input  logic       clear_display,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] port_byte,
  output logic       last_byte,
  input  logic       wr_en,
  input  logic       wr_data
);

  logic   board_wiring;
  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Wiring register.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_wiring <= WIRING_HIGH;
    end else if (wr_en) begin
      board_wiring <= wr_data;
    end
  end

  clne_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (kind),
    .char_code     (char_code),
    .clear_display (clear_display),
    .push          (push),
    .push_entry    (push_entry)
  );

  clne_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  clne_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wiring     (board_wiring),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .port_byte  (port_byte),
    .last_byte  (last_byte)
  );

  // A full queue always has an entry at its head.
  assert property (@(posedge clk) disable iff (rst) q_full |-> q_valid)
    else $error("queue full without a head entry");

  // Control codes never reach the queue.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_CHAR) && (char_code < FIRST_PRINT)) |-> !push)
    else $error("control code queued");

  // Every init word is queued.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_INIT)) |-> push)
    else $error("init word dropped");

  // Output channel is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for char_lcd_nibble_expander_encoder_top.
// Predicts the expander byte stream for every word sent and checks each byte in order.
// Depends on clne_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
  import clne_pkg::*;

  // One input word with the idle cycles that come before it.
  typedef struct {
    logic        kind;
    logic [7:0]  code;
    logic        clr;
    int unsigned gap;
  } lcd_word_t;

  // One expected expander byte.
  typedef struct packed {
    logic [7:0] pins;
    logic       last;
  } port_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = KIND_CHAR;
  logic [7:0] char_code = 8'h00;
  logic       clear_display = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] port_byte;
  logic       last_byte;
  logic       wr_en = 1'b0;
  logic       wr_data = 1'b0;

  // Words waiting to be driven, and the bytes the display port should produce.
  lcd_word_t  word_q[$];
  port_byte_t port_byte_q[$];
  logic [7:0] burst_q[$];

  // Shadow copy of the block's wiring register and cursor.
  logic       wiring_m = WIRING_HIGH;
  logic [6:0] cursor_m = '0;

  logic        calm_phase = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned words_sent = 0;
  int unsigned init_count = 0;
  int unsigned line_cmd_count = 0;
  int unsigned full_screen_count = 0;

  char_lcd_nibble_expander_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .char_code    (char_code),
    .clear_display(clear_display),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .port_byte    (port_byte),
    .last_byte    (last_byte),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle cycles before a word or after a byte; none at all in a calm phase.
  function automatic int unsigned draw_wait();
    if (calm_phase || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // A 4-bit write becomes the pins, their complement and two idle bytes.
  function automatic void add_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] pins;
    if (wiring_m == WIRING_HIGH) begin
      pins = {nib, 4'h0} | (rs ? RS_HIGH_WIRE : 8'h00);
    end else begin
      pins = {4'h0, nib} | (rs ? RS_LOW_WIRE : 8'h00);
    end
    burst_q.push_back(pins);
    burst_q.push_back(~pins);
    burst_q.push_back(8'hFF);
    burst_q.push_back(8'hFF);
  endfunction

  // A full byte goes out high nibble first.
  function automatic void add_lcd_byte(input logic [7:0] b, input logic rs);
    add_nibble(b[7:4], rs);
    add_nibble(b[3:0], rs);
  endfunction

  // Work out the bytes a word causes and update the shadow cursor.
  function automatic void predict_port_bytes(input lcd_word_t w);
    port_byte_t pb;
    burst_q.delete();
    if (w.kind == KIND_INIT) begin
      cursor_m = '0;
      init_count++;
      add_nibble(WAKE_NIB, 1'b0);
      add_nibble(WAKE_NIB, 1'b0);
      add_nibble(WAKE_NIB, 1'b0);
      add_nibble(WAKE_LAST_NIB, 1'b0);
      add_lcd_byte(CMD_FUNC_SET, 1'b0);
      add_lcd_byte(CMD_DISP_ON, 1'b0);
      add_lcd_byte(w.clr ? CMD_CLEAR : CMD_HOME, 1'b0);
      add_lcd_byte(CMD_ENTRY, 1'b0);
      if (w.clr) begin
        add_lcd_byte(CMD_ADDR_ZERO, 1'b0);
      end
    end else if (w.code >= FIRST_PRINT) begin
      if (cursor_m < SCREEN_CHARS) begin
        // Moving onto a new line needs its address command first.
        if (cursor_m == LINE_LENGTH) begin
          add_lcd_byte(CMD_LINE2, 1'b0);
          line_cmd_count++;
        end else if (cursor_m == 2 * LINE_LENGTH) begin
          add_lcd_byte(CMD_LINE3, 1'b0);
          line_cmd_count++;
        end else if (cursor_m == 3 * LINE_LENGTH) begin
          add_lcd_byte(CMD_LINE4, 1'b0);
          line_cmd_count++;
        end
        add_lcd_byte(w.code, 1'b1);
        cursor_m = cursor_m + 7'd1;
      end else begin
        full_screen_count++;
      end
    end
    for (int i = 0; i < burst_q.size(); i++) begin
      pb.pins = burst_q[i];
      pb.last = (i == burst_q.size() - 1);
      port_byte_q.push_back(pb);
    end
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Input driver: present words from the queue after their idle gap.
  // The prediction is made when a word is first shown, since it is then sure to be taken.
  always @(posedge clk) begin
    lcd_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else if (!(in_valid && in_stall)) begin
      if (word_q.size() != 0 && gap_cnt >= word_q[0].gap) begin
        nxt = word_q.pop_front();
        predict_port_bytes(nxt);
        words_sent++;
        kind          <= nxt.kind;
        char_code     <= nxt.code;
        clear_display <= nxt.clr;
        in_valid      <= 1'b1;
        gap_cnt = 0;
      end else begin
        in_valid <= 1'b0;
        if (word_q.size() != 0) begin
          gap_cnt++;
        end
      end
    end
  end

  // Output monitor: check every accepted byte and stall at random between bytes.
  always @(posedge clk) begin
    port_byte_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (port_byte_q.size() == 0) begin
          report_mismatch("byte with nothing expected", int'(port_byte), 0);
        end else begin
          want = port_byte_q.pop_front();
          if (port_byte !== want.pins) begin
            report_mismatch("port_byte", int'(port_byte), int'(want.pins));
          end
          if (last_byte !== want.last) begin
            report_mismatch("last_byte", int'(last_byte), int'(want.last));
          end
        end
        bytes_checked++;
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_word(input logic k, input logic [7:0] c, input logic clr);
    lcd_word_t w;
    w.kind = k;
    w.code = c;
    w.clr  = clr;
    w.gap  = draw_wait();
    word_q.push_back(w);
  endtask

  // Hold the sender until every byte has come out, then allow the pipeline to settle.
  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || port_byte_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_wiring(input logic value);
    @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= value;
    wiring_m = value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Mostly init followed by a run of text, some long enough to fill the screen;
  // the rest are loose random words.
  task automatic queue_random_words(input int target);
    int n;
    int run;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_word(KIND_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run = ($urandom_range(0, 2) == 0) ? $urandom_range(78, 95) : $urandom_range(0, 60);
        for (int i = 0; i < run; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_word(KIND_CHAR, 8'($urandom_range(0, 8'h1F)), 1'($urandom_range(0, 1)));
          end else begin
            queue_word(KIND_CHAR, 8'($urandom_range(FIRST_PRINT, 8'hFF)),
                       1'($urandom_range(0, 1)));
          end
        end
        n += run + 1;
      end else begin
        run = $urandom_range(1, 10);
        for (int i = 0; i < run; i++) begin
          queue_word(($urandom_range(0, 9) < 3) ? KIND_INIT : KIND_CHAR,
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        n += run;
      end
    end
  endtask

  // Stimulus: directed words under both wirings, then random phases.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset wiring: text before any init, control codes, ignored fields, both inits.
    queue_word(KIND_CHAR, 8'h41, 1'b0);
    queue_word(KIND_CHAR, 8'h1F, 1'b0);
    queue_word(KIND_CHAR, 8'h00, 1'b1);
    queue_word(KIND_INIT, 8'hFF, 1'b1);
    queue_word(KIND_CHAR, 8'h20, 1'b1);
    queue_word(KIND_CHAR, 8'hFF, 1'b0);
    queue_word(KIND_CHAR, 8'h80, 1'b0);
    queue_word(KIND_CHAR, 8'h7F, 1'b0);
    queue_word(KIND_CHAR, 8'h5A, 1'b0);
    queue_word(KIND_CHAR, 8'hA5, 1'b1);
    queue_word(KIND_INIT, 8'h00, 1'b0);
    queue_word(KIND_CHAR, 8'h01, 1'b0);
    wait_idle();

    // Low-nibble wiring with the same kinds of words.
    write_wiring(WIRING_LOW);
    queue_word(KIND_INIT, 8'h55, 1'b1);
    queue_word(KIND_CHAR, 8'h20, 1'b0);
    queue_word(KIND_CHAR, 8'hFF, 1'b1);
    queue_word(KIND_CHAR, 8'h10, 1'b0);
    queue_word(KIND_CHAR, 8'hF0, 1'b0);
    queue_word(KIND_CHAR, 8'h3C, 1'b0);
    queue_word(KIND_INIT, 8'hAA, 1'b0);
    queue_word(KIND_CHAR, 8'h0F, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_wiring((p < 4) ? logic'(p % 2 == 0) : logic'($urandom_range(0, 1)));
      calm_phase = (p == 2);
      queue_random_words(30);
      wait_idle();
    end

    $display("Covered %0d words: %0d inits, %0d line-address commands, %0d at a full screen.",
             words_sent, init_count, line_cmd_count, full_screen_count);
    $display("Checked %0d expander bytes under both board wirings.", bytes_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(64'd50_000_000);
    $display("Timeout with %0d bytes still expected.", port_byte_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
